@@ rtl/tcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Geometry defaults, field widths, character codes, operation codes, the
// sequencer state type and the status bundle passed to the top level.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned OCOL_W = 7;
  localparam int unsigned OROW_W = 5;
  localparam int unsigned CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_BLANK,
    ST_GLYPH,
    ST_TAB,
    ST_RDATA,
    ST_CLEAR,
    ST_SCROLL,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              res_valid;
    logic              attr_reset;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [OCOL_W-1:0] cursor_column;
    logic [OROW_W-1:0] cursor_row;
  } seq_status_t;

endpackage
`default_nettype wire

@@ rtl/tcw_screen_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_screen_ram: character cell memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int unsigned AW    = 11,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [tcw_pkg::CELL_W-1:0]  wdata_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic      [tcw_pkg::CELL_W-1:0]  rdata_o
);

  logic [tcw_pkg::CELL_W-1:0] mem_q [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/tcw_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_sequencer: cursor, item decode and memory walk sequencer
// A single address counter with its end compare drives the clearing, scroll
// copy and blank passes; the cursor is updated one step per cycle.
// ----------------------------------------------------------------------------
module tcw_sequencer #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF,
  parameter int unsigned AW      = $clog2(ROWS * COLUMNS)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [tcw_pkg::OP_W-1:0]    op_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  char_i,
  input  wire logic [tcw_pkg::IDX_W-1:0]   idx_i,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  attr_i,
  input  wire logic                        out_free_i,
  output tcw_pkg::seq_status_t             status_o,
  output logic                             ram_we_o,
  output logic      [AW-1:0]               ram_waddr_o,
  output logic      [tcw_pkg::CELL_W-1:0]  ram_wdata_o,
  output logic      [AW-1:0]               ram_raddr_o,
  input  wire logic [tcw_pkg::CELL_W-1:0]  ram_rdata_i
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned IW    = ((AW > tcw_pkg::IDX_W) ? AW : tcw_pkg::IDX_W) + 1;

  localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LIMIT = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] COL_END    = CW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);

  tcw_pkg::state_e state_q, state_d;

  logic [tcw_pkg::OP_W-1:0]   op_q;
  logic [tcw_pkg::CHAR_W-1:0] char_q;
  logic [tcw_pkg::IDX_W-1:0]  idx_q;
  logic [CW-1:0]              col_q, col_d;
  logic [RW-1:0]              row_q, row_d;
  logic [AW-1:0]              walk_q, walk_d;
  logic                       pend_q, pend_d;
  logic                       pend_blank_q, pend_blank_d;
  logic [AW-1:0]              pend_addr_q, pend_addr_d;
  logic [tcw_pkg::CHAR_W-1:0] rc_q, rc_d;
  logic [tcw_pkg::ATTR_W-1:0] ra_q, ra_d;

  logic                       accept;
  logic                       walk_end;
  logic                       last_row;
  logic                       row_full;
  logic [CW-1:0]              col_inc;
  logic [AW-1:0]              cur_addr;
  logic [IW-1:0]              idx_ext;
  logic                       idx_in_range;
  logic [CW+6:0]              col_ext;
  logic [RW+4:0]              row_ext;

  assign accept       = in_valid_i && in_ready_o;
  assign walk_end     = (walk_q == LAST_CELL);
  assign last_row     = (row_q == ROW_LAST);
  assign row_full     = (col_q == COL_END);
  assign col_inc      = col_q + 1'b1;
  assign cur_addr     = AW'(row_q) * COLS_A + AW'(col_q);
  assign idx_ext      = IW'(idx_q);
  assign idx_in_range = (idx_ext < IW'(CELLS));
  assign col_ext      = (CW + 7)'(col_q);
  assign row_ext      = (RW + 5)'(row_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::ST_INIT: begin
        if (walk_end) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) state_d = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        case (op_q)
          tcw_pkg::OP_PUT: begin
            case (char_q)
              tcw_pkg::CH_NUL, tcw_pkg::CH_CR: state_d = tcw_pkg::ST_DONE;
              tcw_pkg::CH_LF: begin
                state_d = last_row ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_DONE;
              end
              tcw_pkg::CH_BS: state_d = tcw_pkg::ST_BLANK;
              tcw_pkg::CH_TAB: begin
                state_d = (row_full && last_row) ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_TAB;
              end
              default: begin
                state_d = (row_full && last_row) ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_GLYPH;
              end
            endcase
          end
          tcw_pkg::OP_READ:  state_d = tcw_pkg::ST_RDATA;
          tcw_pkg::OP_CLEAR: state_d = tcw_pkg::ST_CLEAR;
          default:           state_d = tcw_pkg::ST_DONE;
        endcase
      end
      tcw_pkg::ST_BLANK, tcw_pkg::ST_GLYPH, tcw_pkg::ST_RDATA: begin
        state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_TAB: begin
        if (col_inc[1:0] == 2'b00 || col_inc == COL_END) state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_CLEAR: begin
        if (walk_end) state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_SCROLL: begin
        if (walk_end) state_d = tcw_pkg::ST_FLUSH;
      end
      tcw_pkg::ST_FLUSH: begin
        // The put that needed the scroll continues on the fresh bottom row.
        if (char_q == tcw_pkg::CH_LF) begin
          state_d = tcw_pkg::ST_DONE;
        end else if (char_q == tcw_pkg::CH_TAB) begin
          state_d = tcw_pkg::ST_TAB;
        end else begin
          state_d = tcw_pkg::ST_GLYPH;
        end
      end
      tcw_pkg::ST_DONE: begin
        if (out_free_i) state_d = tcw_pkg::ST_IDLE;
      end
      default: state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  // Memory port and handshake outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_addr;
    ram_wdata_o = {attr_i, tcw_pkg::CH_SPACE};
    ram_raddr_o = walk_q + COLS_A;
    status_o.res_valid  = 1'b0;
    status_o.attr_reset = 1'b0;
    unique case (state_q)
      tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = walk_q;
        ram_wdata_o = {tcw_pkg::DEFAULT_ATTR, tcw_pkg::CH_SPACE};
      end
      tcw_pkg::ST_IDLE: in_ready_o = 1'b1;
      tcw_pkg::ST_EXEC: begin
        ram_raddr_o = idx_ext[AW-1:0];
        status_o.attr_reset = (op_q == tcw_pkg::OP_CLEAR);
      end
      tcw_pkg::ST_BLANK, tcw_pkg::ST_TAB: ram_we_o = 1'b1;
      tcw_pkg::ST_GLYPH: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = {attr_i, char_q};
      end
      tcw_pkg::ST_SCROLL, tcw_pkg::ST_FLUSH: begin
        ram_we_o    = pend_q;
        ram_waddr_o = pend_addr_q;
        ram_wdata_o = pend_blank_q ? {attr_i, tcw_pkg::CH_SPACE} : ram_rdata_i;
      end
      tcw_pkg::ST_DONE: status_o.res_valid = 1'b1;
      default: ;
    endcase
    status_o.cell_char     = rc_q;
    status_o.cell_attr     = ra_q;
    status_o.cursor_column = col_ext[tcw_pkg::OCOL_W-1:0];
    status_o.cursor_row    = row_ext[tcw_pkg::OROW_W-1:0];
  end

  // Cursor, walk counter and copy pipeline.
  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    walk_d       = '0;
    pend_d       = 1'b0;
    pend_blank_d = pend_blank_q;
    pend_addr_d  = pend_addr_q;
    rc_d         = rc_q;
    ra_d         = ra_q;
    unique case (state_q)
      tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
        walk_d = walk_q + 1'b1;
      end
      tcw_pkg::ST_EXEC: begin
        rc_d = '0;
        ra_d = '0;
        case (op_q)
          tcw_pkg::OP_PUT: begin
            case (char_q)
              tcw_pkg::CH_NUL: ;
              tcw_pkg::CH_CR: col_d = '0;
              tcw_pkg::CH_LF: begin
                col_d = '0;
                if (!last_row) row_d = row_q + 1'b1;
              end
              tcw_pkg::CH_BS: begin
                if (col_q == '0 && row_q != '0) begin
                  row_d = row_q - 1'b1;
                  col_d = COL_LAST;
                end else if (col_q != '0) begin
                  col_d = col_q - 1'b1;
                end
              end
              default: begin
                // A full row wraps before the glyph or tab is placed.
                if (row_full) begin
                  col_d = '0;
                  if (!last_row) row_d = row_q + 1'b1;
                end
              end
            endcase
          end
          tcw_pkg::OP_CLEAR: begin
            col_d = '0;
            row_d = '0;
          end
          default: ;
        endcase
      end
      tcw_pkg::ST_GLYPH, tcw_pkg::ST_TAB: col_d = col_inc;
      tcw_pkg::ST_RDATA: begin
        if (idx_in_range) begin
          rc_d = ram_rdata_i[tcw_pkg::CHAR_W-1:0];
          ra_d = ram_rdata_i[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // Cell k is read one row below and written in the next cycle; bottom-row cells are written blank.
        walk_d       = walk_q + 1'b1;
        pend_d       = 1'b1;
        pend_addr_d  = walk_q;
        pend_blank_d = (walk_q >= COPY_LIMIT);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_INIT;
      col_q   <= '0;
      row_q   <= '0;
      walk_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      walk_q  <= walk_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      char_q <= char_i;
      idx_q  <= idx_i;
    end
    pend_blank_q <= pend_blank_d;
    pend_addr_q  <= pend_addr_d;
    rc_q         <= rc_d;
    ra_q         <= ra_d;
  end

endmodule
`default_nettype wire

@@ rtl/text_console_writer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_unit: text console with screen memory and cursor
// Takes put, read and clear items and returns one status item for each.
// ----------------------------------------------------------------------------
// Each item is decoded and executed and its result is loaded into the output
// register before the next item is taken; a tab makes one memory write per
// blanked cell. A scroll and a clear walk every cell through the one write port.
// After reset a clearing pass blanks all ROWS*COLUMNS cells while no item is
// accepted; the cursor is homed and the attribute is 7.
module text_console_writer_unit #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,      // color_attribute
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,    // char_code[7:0], cell_index[18:8], zero
  input  wire logic [1:0]  s_axis_tuser,    // op[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata     // cell_char[7:0], cell_attr[15:8],
                                            // cursor_column[22:16], cursor_row[27:23], zero
);

  localparam int unsigned AW = $clog2(ROWS * COLUMNS);

  logic [tcw_pkg::ATTR_W-1:0] attr_q, attr_d;
  logic                       m_valid_q, m_valid_d;
  logic [27:0]                m_data_q;
  logic                       out_free;
  logic                       load;

  tcw_pkg::seq_status_t       status;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  assign out_free = !m_valid_q || m_axis_tready;
  assign load     = status.res_valid && out_free;

  always_comb begin
    attr_d = attr_q;
    if (status.attr_reset) begin
      attr_d = tcw_pkg::DEFAULT_ATTR;
    end else if (cfg_valid_i) begin
      attr_d = cfg_data_i;
    end
    m_valid_d = m_valid_q;
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q    <= tcw_pkg::DEFAULT_ATTR;
      m_valid_q <= 1'b0;
    end else begin
      attr_q    <= attr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= {status.cursor_row, status.cursor_column, status.cell_attr, status.cell_char};
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_data_q};

  tcw_sequencer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_sequencer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .char_i      (s_axis_tdata[7:0]),
    .idx_i       (s_axis_tdata[18:8]),
    .attr_i      (attr_q),
    .out_free_i  (out_free),
    .status_o    (status),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tcw_screen_ram #(
    .AW    (AW),
    .DEPTH (ROWS * COLUMNS)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire
